/* src/bptc_pkg.sv */
`timescale 1ns / 1ps

package bptc_pkg;

	// Configuration register indexes
	localparam logic [7:0] REG_CAL_A    = 8'd0;
	localparam logic [7:0] REG_CAL_B    = 8'd1;
	localparam logic [7:0] REG_CAL_C    = 8'd2;
	localparam logic [7:0] REG_P_OFFSET = 8'd3;

	localparam int unsigned CFG_INDEX_W = 8;
	localparam int unsigned CFG_DATA_W  = 64;

	localparam logic [16:0] P_OFFSET_RST = 17'd99880;

	// Depth of the queue between front and back
	localparam int unsigned BPTC_QUEUE_DEPTH = 4;

	// Number of registered stages in the back part, output register included
	localparam int unsigned BACK_STAGES = 14;

	localparam logic [31:0] RAW_MID      = 32'd8388608;
	localparam logic [31:0] K_C1         = 32'd4459;
	localparam logic [31:0] K_C2         = 32'd256;
	localparam logic [31:0] T_BASE       = 32'd81920000;  // 2500 << 15
	localparam logic [31:0] K_C5         = 32'd4443;
	localparam logic [31:0] K_C4         = 32'd120586;
	localparam logic [31:0] K_C8         = 32'd7180;
	localparam logic [31:0] K_C7         = 32'd166426;
	localparam logic [31:0] LOW11_MASK   = 32'h0000_07FF;
	localparam logic [31:0] CF_BASE      = 32'd2097152;

	typedef struct packed {
		logic [11:0] c0;
		logic [10:0] c1;
		logic [8:0]  c2;
		logic [12:0] c3;
		logic [17:0] c4;
		logic [14:0] c5;
		logic [12:0] c6;
		logic [18:0] c7;
		logic [12:0] c8;
		logic [13:0] c9;
		logic [9:0]  c10;
		logic [7:0]  c11;
		logic [4:0]  c12;
	} coef_t;

	// One queued reading pair, already offset and with dT formed
	typedef struct packed {
		logic [31:0] pu;
		logic [31:0] dt;
	} entry_t;

	function automatic logic [31:0] sra(input logic [31:0] x, input int unsigned n);
		logic signed [31:0] xs;
		xs = x;
		return 32'(xs >>> n);
	endfunction

	function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
		logic [63:0] p;
		p = {32'd0, a} * {32'd0, b};
		return p[31:0];
	endfunction

	function automatic logic sge(input logic [31:0] a, input logic [31:0] b);
		return $signed(a) >= $signed(b);
	endfunction

	function automatic coef_t unpack_cal(input logic [63:0] a, input logic [63:0] b,
			input logic [31:0] c);
		logic [15:0] w0, w1, w2, w3, w4, w5, w6, w7, w8, w9;
		coef_t k;
		w0 = a[63:48];
		w1 = a[47:32];
		w2 = a[31:16];
		w3 = a[15:0];
		w4 = b[63:48];
		w5 = b[47:32];
		w6 = b[31:16];
		w7 = b[15:0];
		w8 = c[31:16];
		w9 = c[15:0];
		k.c0  = w0[15:4];
		k.c1  = {w1[15:8], w2[2:0]};
		k.c2  = {w1[7:0], w4[0]};
		k.c3  = w2[15:3];
		k.c4  = {w3, w0[1:0]};
		k.c5  = w4[15:1];
		k.c6  = w5[15:3];
		k.c7  = {w6, w5[2:0]};
		k.c8  = w7[15:3];
		k.c9  = w8[15:2];
		k.c10 = {w9[15:8], w8[1:0]};
		k.c11 = w9[7:0];
		k.c12 = {w0[3:2], w7[2:0]};
		return k;
	endfunction

endpackage

/* src/bptc_front.sv */
`timescale 1ns / 1ps

module bptc_front import bptc_pkg::*; (
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [23:0] raw_pressure,
	input  logic [23:0] raw_temperature,
	input  logic [11:0] c0,
	input  logic        q_full,
	output logic        push,
	output entry_t      push_data
);

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	// Center both readings on mid-scale and form dT
	always_comb begin
		push_data.pu = {8'd0, raw_pressure} - RAW_MID;
		push_data.dt = sra({8'd0, raw_temperature} - RAW_MID, 4) + {16'd0, c0, 4'd0};
	end

endmodule

/* src/bptc_queue.sv */
`timescale 1ns / 1ps

module bptc_queue import bptc_pkg::*; #(
	parameter int unsigned DEPTH = BPTC_QUEUE_DEPTH
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_data,
	output logic   full,
	input  logic   pop,
	output logic   not_empty,
	output entry_t head
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	entry_t        mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full      = cnt_q == CW'(DEPTH);
	assign not_empty = cnt_q != '0;
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* src/bptc_back.sv */
`timescale 1ns / 1ps

module bptc_back import bptc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  coef_t              coef,
	input  logic [16:0]        p_offset,
	input  logic               q_valid,
	input  entry_t             q_head,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [16:0] temperature_centi,
	output logic signed [31:0] pressure_pa
);

	logic [BACK_STAGES-1:0] vld_q;
	logic                   en;

	logic [31:0] k1, k2, k5, k8, k7, k4;

	// stage 1
	logic [31:0] pu_s1, dt_s1, x01_s1, t2_s1, t3_s1;
	// stage 2
	logic [31:0] pu_s2, dt_s2, x01_s2, x02_s2, u3_s2;
	// stage 3
	logic [31:0] pu_s3, x01_s3, x02_s3, x03_s3;
	// stage 4
	logic [31:0] pu_s4, dt2_s4;
	logic [16:0] rt_s4;
	// stage 5
	logic [31:0] pu_s5, dt2_s5, x11_s5, y12_s5, x21_s5, y22_s5, m12_s5;
	logic [16:0] rt_s5;
	// stage 6
	logic [31:0] pu_s6, x11_s6, x12_s6, x21_s6, x22_s6, cf_s6;
	logic [16:0] rt_s6;
	// stage 7
	logic [31:0] pu_s7, x13_s7, x23_s7, q10_s7, q11_s7;
	logic        ge_s7;
	logic [16:0] rt_s7;
	// stage 8
	logic [31:0] pp1_s8, x24_s8, x25_s8, q10_s8, q11_s8;
	logic        ge_s8;
	logic [16:0] rt_s8;
	// stage 9
	logic [31:0] pp1_s9, x26_s9, q10_s9, q11_s9;
	logic [16:0] rt_s9;
	// stage 10
	logic [31:0] pp2_s10, pp3_s10, q10_s10, q11_s10;
	logic [16:0] rt_s10;
	// stage 11
	logic [31:0] pp4_s11, q10_s11, q11_s11;
	logic [16:0] rt_s11;
	// stage 12
	logic [31:0] pp4_s12, x31_s12, v32_s12;
	logic [16:0] rt_s12;
	// stage 13
	logic [31:0] pp4_s13, x31_s13, x32_s13;
	logic [16:0] rt_s13;
	// stage 14 (output register)
	logic [31:0] rp_s14;
	logic [16:0] rt_s14;

	logic [31:0] x22_c, x21_c, x24_c, x25_c;

	assign k1 = {21'd0, coef.c1} + K_C1;
	assign k2 = {23'd0, coef.c2} - K_C2;
	assign k5 = {17'd0, coef.c5} - K_C5;
	assign k8 = {19'd0, coef.c8} + K_C8;
	assign k7 = {13'd0, coef.c7} + K_C7;
	assign k4 = ({14'd0, coef.c4} + K_C4) << 4;

	// Advance the whole line unless the output register holds an untaken result
	assign en  = !(vld_q[BACK_STAGES-1] && out_stall);
	assign pop = en && q_valid;

	assign out_valid         = vld_q[BACK_STAGES-1];
	assign temperature_centi = $signed(rt_s14);
	assign pressure_pa       = $signed(rp_s14);

	assign x21_c = x21_s6;
	assign x22_c = x22_s6;
	assign x24_c = x24_s8;
	assign x25_c = x25_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[BACK_STAGES-2:0], q_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// temperature polynomial, first products
			pu_s1  <= q_head.pu;
			dt_s1  <= q_head.dt;
			x01_s1 <= sra(mul32(k1, q_head.dt), 1);
			t2_s1  <= sra(mul32(k2, q_head.dt), 14);
			t3_s1  <= sra(mul32({19'd0, coef.c3}, q_head.dt), 18);

			pu_s2  <= pu_s1;
			dt_s2  <= dt_s1;
			x01_s2 <= x01_s1;
			x02_s2 <= sra(mul32(t2_s1, dt_s1), 4);
			u3_s2  <= sra(mul32(t3_s1, dt_s1), 18);

			pu_s3  <= pu_s2;
			x01_s3 <= x01_s2;
			x02_s3 <= x02_s2;
			x03_s3 <= mul32(u3_s2, dt_s2);

			// temperature result and the second-order dT
			pu_s4  <= pu_s3;
			rt_s4  <= 17'(sra(T_BASE - x01_s3 - x02_s3 - x03_s3, 15));
			dt2_s4 <= sra(x01_s3 + x02_s3 + x03_s3, 12);

			pu_s5  <= pu_s4;
			rt_s5  <= rt_s4;
			dt2_s5 <= dt2_s4;
			x11_s5 <= mul32(k5, dt2_s4);
			y12_s5 <= sra(mul32({19'd0, coef.c6}, dt2_s4), 16);
			x21_s5 <= sra(mul32(k8, dt2_s4), 10);
			y22_s5 <= sra(mul32({18'd0, coef.c9}, dt2_s4), 17);
			m12_s5 <= mul32({27'd0, coef.c12}, dt2_s4);

			pu_s6  <= pu_s5;
			rt_s6  <= rt_s5;
			x11_s6 <= x11_s5;
			x12_s6 <= sra(mul32(y12_s5, dt2_s5), 2);
			x21_s6 <= x21_s5;
			x22_s6 <= sra(mul32(y22_s5, dt2_s5), 12);
			cf_s6  <= sra(CF_BASE + m12_s5, 3);

			// offset term, sensitivity difference and its sign
			pu_s7  <= pu_s6;
			rt_s7  <= rt_s6;
			x13_s7 <= sra(x11_s6 + x12_s6, 10) + k4;
			x23_s7 <= sge(x22_c, x21_c) ? (x22_c - x21_c) : (x21_c - x22_c);
			ge_s7  <= sge(x21_c, x22_c);
			q10_s7 <= sra(mul32(cf_s6, {22'd0, coef.c10}), 17);
			q11_s7 <= sra(mul32(cf_s6, {24'd0, coef.c11}), 15);

			rt_s8  <= rt_s7;
			ge_s8  <= ge_s7;
			q10_s8 <= q10_s7;
			q11_s8 <= q11_s7;
			pp1_s8 <= sra(pu_s7 - x13_s7, 3);
			x24_s8 <= mul32(sra(x23_s7, 11), k7);
			x25_s8 <= sra(mul32(x23_s7 & LOW11_MASK, k7), 11);

			rt_s9  <= rt_s8;
			pp1_s9 <= pp1_s8;
			q10_s9 <= q10_s8;
			q11_s9 <= q11_s8;
			x26_s9 <= ge_s8 ? (sra(32'd0 - x24_c - x25_c, 11) + k7)
			                : (sra(x24_c + x25_c, 11) + k7);

			// scale the pressure by the sensitivity in two halves
			rt_s10  <= rt_s9;
			q10_s10 <= q10_s9;
			q11_s10 <= q11_s9;
			pp2_s10 <= mul32(sra(x26_s9, 11), pp1_s9);
			pp3_s10 <= sra(mul32(x26_s9 & LOW11_MASK, pp1_s9), 11);

			rt_s11  <= rt_s10;
			q10_s11 <= q10_s10;
			q11_s11 <= q11_s10;
			pp4_s11 <= sra(pp2_s10 + pp3_s10, 10);

			rt_s12  <= rt_s11;
			pp4_s12 <= pp4_s11;
			x31_s12 <= sra(mul32(q10_s11, pp4_s11), 2);
			v32_s12 <= sra(mul32(q11_s11, pp4_s11), 18);

			rt_s13  <= rt_s12;
			pp4_s13 <= pp4_s12;
			x31_s13 <= x31_s12;
			x32_s13 <= mul32(v32_s12, pp4_s12);

			rt_s14 <= rt_s13;
			rp_s14 <= sra(x31_s13 + x32_s13, 15) + pp4_s13 + {15'd0, p_offset};
		end
	end

endmodule

/* src/baro_pressure_temp_compensation.sv */
`timescale 1ns / 1ps

// A reading pair taken at a clock edge is written to the queue, then popped into
//   stage 1 and carried through the stages to the stage 14 output register.
// Throughput: one reading pair per cycle unless the output stalls; multiplies are registered.
// Reset (arst_n low): calibration words clear to zero, pressure offset returns to
//   99880 Pa, the queue empties and all stage valid bits clear; no clearing pass.
module baro_pressure_temp_compensation import bptc_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = BPTC_QUEUE_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// input readings
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [23:0]            raw_pressure,
	input  logic [23:0]            raw_temperature,
	// results
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic signed [16:0]     temperature_centi,
	output logic signed [31:0]     pressure_pa,
	// configuration writes
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic [63:0] cal_a_q;
	logic [63:0] cal_b_q;
	logic [31:0] cal_c_q;
	logic [16:0] p_offset_q;

	coef_t  coef;
	logic   q_full;
	logic   q_push;
	entry_t q_push_data;
	logic   q_pop;
	logic   q_not_empty;
	entry_t q_head;

	// Configuration is always taken in one beat; writes to unknown indexes drop
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_a_q    <= '0;
			cal_b_q    <= '0;
			cal_c_q    <= '0;
			p_offset_q <= P_OFFSET_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CAL_A:    cal_a_q    <= cfg_data;
				REG_CAL_B:    cal_b_q    <= cfg_data;
				REG_CAL_C:    cal_c_q    <= cfg_data[31:0];
				REG_P_OFFSET: p_offset_q <= cfg_data[16:0];
				default:      ;
			endcase
		end
	end

	// Slice the ten calibration words into the thirteen coefficients.
	// The user must change configuration only while idle; the block does not enforce this, and no pipeline copy is kept.
	assign coef = unpack_cal(cal_a_q, cal_b_q, cal_c_q);

	// Front: take a reading pair whenever the queue has room, form dT
	bptc_front u_front (
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.raw_pressure    (raw_pressure),
		.raw_temperature (raw_temperature),
		.c0              (coef.c0),
		.q_full          (q_full),
		.push            (q_push),
		.push_data       (q_push_data)
	);

	// Short queue decouples input acceptance from output back-pressure
	bptc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	// Back: multiplier pipeline, last stage is the output register
	bptc_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.coef              (coef),
		.p_offset          (p_offset_q),
		.q_valid           (q_not_empty),
		.q_head            (q_head),
		.pop               (q_pop),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.temperature_centi (temperature_centi),
		.pressure_pa       (pressure_pa)
	);

endmodule

/* sim/baro_comp_checker.sv */
`timescale 1ns / 1ps

// Watch the reading, result and configuration channels of the compensation block.
// Predict every reading beat and compare each result beat with the oldest prediction.
module baro_comp_checker import bptc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_stall,
	input  logic [23:0]            raw_pressure,
	input  logic [23:0]            raw_temperature,
	input  logic                   out_valid,
	input  logic                   out_stall,
	input  logic signed [16:0]     temperature_centi,
	input  logic signed [31:0]     pressure_pa,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output int                     backlog,
	output int                     mismatch_count
);

	localparam logic signed [31:0] RAW_ZERO_POINT = 32'sd8388608;
	localparam logic signed [31:0] TEMP_ORIGIN    = 32'sd81920000;  // 25.00 C scaled by 2^15
	localparam logic [16:0]        OFFSET_DEFAULT = 17'd99880;

	typedef struct packed {
		logic signed [16:0] temperature;
		logic signed [31:0] pressure;
	} compensated_t;

	logic [63:0]  cal_a_copy;
	logic [63:0]  cal_b_copy;
	logic [31:0]  cal_c_copy;
	logic [16:0]  offset_copy;
	compensated_t compensated_q[$];
	compensated_t oldest;

	function automatic logic signed [31:0] asr(input logic signed [31:0] v, input int unsigned n);
		return v >>> n;
	endfunction

	function automatic compensated_t compensate(input logic [63:0] wa, input logic [63:0] wb,
			input logic [31:0] wc, input logic [16:0] offset, input logic [23:0] raw_p,
			input logic [23:0] raw_t);
		logic [31:0] w0, w1, w2, w3, w4, w5, w6, w7, w8, w9;
		logic signed [31:0] c0, c1, c2, c3, c4, c5, c6, c7, c8, c9, c10, c11, c12;
		logic signed [31:0] up, ut, dt, x01, x02, x03, rt, dt2;
		logic signed [31:0] x11, x12, x13, x21, x22, x23, x24, x25, x26, k7;
		logic signed [31:0] pp1, pp2, pp3, pp4, cf, x31, x32, rp;
		compensated_t r;
		w0 = wa[63:48];
		w1 = wa[47:32];
		w2 = wa[31:16];
		w3 = wa[15:0];
		w4 = wb[63:48];
		w5 = wb[47:32];
		w6 = wb[31:16];
		w7 = wb[15:0];
		w8 = wc[31:16];
		w9 = wc[15:0];

		c0  = w0 >> 4;
		c1  = ((w1 & 32'hFF00) >> 5) | (w2 & 32'h7);
		c2  = ((w1 & 32'hFF) << 1) | (w4 & 32'h1);
		c3  = w2 >> 3;
		c4  = (w3 << 2) | (w0 & 32'h3);
		c5  = w4 >> 1;
		c6  = w5 >> 3;
		c7  = (w6 << 3) | (w5 & 32'h7);
		c8  = w7 >> 3;
		c9  = w8 >> 2;
		c10 = ((w9 & 32'hFF00) >> 6) | (w8 & 32'h3);
		c11 = w9 & 32'hFF;
		c12 = ((w0 & 32'hC) << 1) | (w7 & 32'h7);

		up = {8'd0, raw_p};
		ut = {8'd0, raw_t};

		// temperature path
		dt  = asr(ut - RAW_ZERO_POINT, 4) + (c0 << 4);
		x01 = asr((c1 + 4459) * dt, 1);
		x02 = asr(asr((c2 - 256) * dt, 14) * dt, 4);
		x03 = asr(asr(c3 * dt, 18) * dt, 18) * dt;
		rt  = asr(TEMP_ORIGIN - x01 - x02 - x03, 15);
		dt2 = asr(x01 + x02 + x03, 12);

		// offset and sensitivity terms
		x11 = (c5 - 4443) * dt2;
		x12 = asr(asr(c6 * dt2, 16) * dt2, 2);
		x13 = asr(x11 + x12, 10) + ((c4 + 120586) << 4);
		x21 = asr((c8 + 7180) * dt2, 10);
		x22 = asr(asr(c9 * dt2, 17) * dt2, 12);
		x23 = (x22 >= x21) ? (x22 - x21) : (x21 - x22);
		k7  = c7 + 166426;
		x24 = asr(x23, 11) * k7;
		x25 = asr((x23 & 32'h7FF) * k7, 11);
		if (x21 >= x22)
			x26 = asr(-x24 - x25, 11) + k7;
		else
			x26 = asr(x24 + x25, 11) + k7;

		// pressure path
		pp1 = asr((up - RAW_ZERO_POINT) - x13, 3);
		pp2 = asr(x26, 11) * pp1;
		pp3 = asr((x26 & 32'h7FF) * pp1, 11);
		pp4 = asr(pp2 + pp3, 10);
		cf  = asr(2097152 + c12 * dt2, 3);
		x31 = asr(asr(cf * c10, 17) * pp4, 2);
		x32 = asr(asr(cf * c11, 15) * pp4, 18) * pp4;
		rp  = asr(x31 + x32, 15) + pp4 + {15'd0, offset};

		r.temperature = rt[16:0];
		r.pressure    = rp;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_a_copy     = '0;
			cal_b_copy     = '0;
			cal_c_copy     = '0;
			offset_copy    = OFFSET_DEFAULT;
			compensated_q.delete();
			backlog        = 0;
			mismatch_count = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_CAL_A:    cal_a_copy  = cfg_data;
					REG_CAL_B:    cal_b_copy  = cfg_data;
					REG_CAL_C:    cal_c_copy  = cfg_data[31:0];
					REG_P_OFFSET: offset_copy = cfg_data[16:0];
					default:      ;  // drop writes to unknown registers
				endcase
			end
			if (out_valid && !out_stall) begin
				if (compensated_q.size() == 0) begin
					$error("result beat with no reading outstanding: temperature_centi %0d, pressure_pa %0d",
						temperature_centi, pressure_pa);
					mismatch_count++;
				end else begin
					oldest = compensated_q.pop_front();
					if (temperature_centi !== oldest.temperature) begin
						$error("temperature_centi: expected %0d, actual %0d",
							oldest.temperature, temperature_centi);
						mismatch_count++;
					end
					if (pressure_pa !== oldest.pressure) begin
						$error("pressure_pa: expected %0d, actual %0d", oldest.pressure, pressure_pa);
						mismatch_count++;
					end
				end
			end
			if (in_valid && !in_stall)
				compensated_q.push_back(compensate(cal_a_copy, cal_b_copy, cal_c_copy, offset_copy,
					raw_pressure, raw_temperature));
			backlog = compensated_q.size();
		end
	end

endmodule

/* sim/tb_baro_pressure_temp_compensation.sv */
`timescale 1ns / 1ps

// Stimulus and verdict for the barometric compensation block. Prediction and
// comparison live in the checker instantiated next to the block.
module tb_baro_pressure_temp_compensation import bptc_pkg::*; ();

	// Padding waited out after the last result comes back, so the pipe can empty.
	localparam int DRAIN_CYCLES   = 24;
	localparam int CYCLE_LIMIT    = 500000;
	localparam int RANDOM_PHASES  = 6;
	localparam int PHASE_READINGS = 175;
	localparam int CORNER_COUNT   = 6;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_RUNS
	} stall_mode_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic [23:0]            raw_pressure = '0;
	logic [23:0]            raw_temperature = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic signed [16:0]     temperature_centi;
	logic signed [31:0]     pressure_pa;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	int backlog;
	int mismatch_count;

	// Receiver back-pressure state, private to the stall process
	stall_mode_t stall_mode = STALL_NONE;
	int          stall_mode_left = 0;
	int          stall_run_left = 0;
	logic        stall_hold = 1'b0;

	baro_pressure_temp_compensation i_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.raw_pressure      (raw_pressure),
		.raw_temperature   (raw_temperature),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.temperature_centi (temperature_centi),
		.pressure_pa       (pressure_pa),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data)
	);

	baro_comp_checker i_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.raw_pressure      (raw_pressure),
		.raw_temperature   (raw_temperature),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.temperature_centi (temperature_centi),
		.pressure_pa       (pressure_pa),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.backlog           (backlog),
		.mismatch_count    (mismatch_count)
	);

	always #4 clk = ~clk;

	// Drive back-pressure on the result side. Switch between modes at random so
	// stalls land on every stage of the pipeline, including long stretches with
	// no stall at all and long solid stall runs.
	always @(negedge clk) begin
		if (stall_mode_left == 0) begin
			stall_mode      = stall_mode_t'($urandom_range(STALL_NONE, STALL_RUNS));
			stall_mode_left = $urandom_range(16, 300);
		end else begin
			stall_mode_left--;
		end
		case (stall_mode)
			STALL_NONE:  out_stall <= 1'b0;
			STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
			default: begin
				// toggle between stalled and open runs of random length
				if (stall_run_left == 0) begin
					stall_hold     = ~stall_hold;
					stall_run_left = $urandom_range(1, 20);
				end else begin
					stall_run_left--;
				end
				out_stall <= stall_hold;
			end
		endcase
	end

	// Offer one reading beat and hold it until the block takes it. Valid stays
	// high on return so back-to-back calls form a burst.
	task automatic offer_reading(input logic [23:0] p, input logic [23:0] t);
		@(negedge clk);
		in_valid        <= 1'b1;
		raw_pressure    <= p;
		raw_temperature <= t;
		do @(posedge clk); while (in_stall);
	endtask

	// Drop valid for a gap of the given number of cycles (at least one).
	task automatic pause_sender(input int cycles);
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	// Stop sending, wait out every outstanding result, then let the pipe empty.
	task automatic settle_pipeline();
		pause_sender(1);
		while (backlog != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Load all four registers while idle. Pad the narrow registers with junk in
	// the unused upper bits, and finish with a write to an index past the map,
	// which the block must drop.
	task automatic load_calibration(input logic [63:0] a, input logic [63:0] b,
			input logic [31:0] c, input logic [16:0] offset);
		write_register(REG_CAL_A, a);
		write_register(REG_CAL_B, b);
		write_register(REG_CAL_C, {32'($urandom()), c});
		write_register(REG_P_OFFSET, {32'($urandom()), 15'($urandom()), offset});
		write_register(CFG_INDEX_W'($urandom_range(int'(REG_P_OFFSET) + 1, 255)),
			{32'($urandom()), 32'($urandom())});
	endtask

	// Send the corner readings: both raw fields at zero, full scale, the midpoint,
	// crossed extremes and a checkerboard.
	task automatic send_corner_readings();
		logic [23:0] p, t;
		for (int k = 0; k < CORNER_COUNT; k++) begin
			case (k)
				0:       begin p = 24'h000000; t = 24'h000000; end
				1:       begin p = 24'hFFFFFF; t = 24'hFFFFFF; end
				2:       begin p = 24'h800000; t = 24'h800000; end
				3:       begin p = 24'h000000; t = 24'hFFFFFF; end
				4:       begin p = 24'hFFFFFF; t = 24'h000000; end
				default: begin p = 24'h5A5A5A; t = 24'hA5A5A5; end
			endcase
			offer_reading(p, t);
			// alternate back-to-back beats with single-cycle gaps
			if (k[0])
				pause_sender(1);
		end
	endtask

	// Half full-range codes, the rest biased toward the midpoint (where the
	// polynomial is best behaved) and toward both rails.
	function automatic logic [23:0] pick_raw_code();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return 24'($urandom());
			5, 6:          return 24'(32'd8388608 + $urandom_range(0, 65535) - 32'd32768);
			7:             return 24'($urandom_range(0, 255));
			8:             return 24'hFFFFFF - 24'($urandom_range(0, 255));
			default:       return 24'(32'd8388608 + $urandom_range(0, 2097151) - 32'd1048576);
		endcase
	endfunction

	function automatic logic [63:0] pick_cal_bits();
		case ($urandom_range(0, 4))
			0:       return '0;
			1:       return '1;
			default: return {32'($urandom()), 32'($urandom())};
		endcase
	endfunction

	// Random readings in bursts of random length with random gaps; optionally
	// hold off once mid-phase until every outstanding result has come back.
	task automatic send_random_readings(input int count, input int hold_off_at);
		int burst_left;
		burst_left = $urandom_range(1, 30);
		for (int i = 0; i < count; i++) begin
			if (i == hold_off_at)
				settle_pipeline();
			offer_reading(pick_raw_code(), pick_raw_code());
			if (burst_left == 0) begin
				burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 200)
					: $urandom_range(1, 30);
				pause_sender($urandom_range(1, 12));
			end else begin
				burst_left--;
			end
		end
	endtask

	// Abort a hung run.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Verification failed");
		$finish;
	end

	initial begin
		logic [16:0] offset;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// Calibration never written: all coefficients zero, default offset.
		send_corner_readings();
		settle_pipeline();

		// Every calibration bit set, offset at its maximum.
		load_calibration('1, '1, '1, 17'h1FFFF);
		send_corner_readings();
		settle_pipeline();

		// Alternating bit patterns, offset at zero.
		load_calibration(64'hAAAA_5555_AAAA_5555, 64'h5555_AAAA_5555_AAAA, 32'hA5A5_5A5A, '0);
		send_corner_readings();
		settle_pipeline();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case ($urandom_range(0, 3))
				0:       offset = '0;
				1:       offset = 17'h1FFFF;
				2:       offset = P_OFFSET_RST;
				default: offset = 17'($urandom());
			endcase
			load_calibration(pick_cal_bits(), pick_cal_bits(), 32'(pick_cal_bits()), offset);
			send_random_readings(PHASE_READINGS, (ph == 1) ? 60 : -1);
			settle_pipeline();
		end

		if (mismatch_count == 0 && backlog == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
